// File: sv/srq_pkg.sv
// Shared types and constants for the sequenced ring queue.
// No dependencies; every other file of the block refers to this package.
package srq_pkg;

  localparam int unsigned DEFAULT_MAX_DEPTH  = 1024;
  localparam int unsigned DEFAULT_ITEM_WIDTH = 64;

  // Fixed field widths of the result item and the configuration register.
  localparam int unsigned CFG_WIDTH   = 4;
  localparam int unsigned FILL_WIDTH  = 11;
  localparam int unsigned COUNT_WIDTH = 32;

  // APB configuration port.
  localparam int unsigned APB_ADDR_WIDTH = 3;
  localparam int unsigned APB_DATA_WIDTH = 32;
  localparam logic        REG_CAPACITY_LOG2 = 1'b0;  // word index of the register

  localparam logic [CFG_WIDTH-1:0] CAP_LOG2_RESET = 4'd10;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_DEQUEUE = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the input item
    logic execute;  // decide, update the ring and the counters
  } dp_cmd_t;

endpackage

// File: sv/srq_if.sv
// Handshake channels of the sequenced ring queue: request and response.
// Depends on srq_pkg for the field widths.
interface srq_req_if #(
  parameter int unsigned ITEM_WIDTH = srq_pkg::DEFAULT_ITEM_WIDTH
);
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [ITEM_WIDTH-1:0] payload;

  modport source (output valid, output opcode, output payload, input ready);
  modport sink   (input valid, input opcode, input payload, output ready);
endinterface

interface srq_rsp_if #(
  parameter int unsigned ITEM_WIDTH = srq_pkg::DEFAULT_ITEM_WIDTH
);
  logic                               valid;
  logic                               ready;
  logic                               accepted;
  logic [ITEM_WIDTH-1:0]              item_out;
  logic [srq_pkg::FILL_WIDTH-1:0]     fill_level;
  logic [srq_pkg::FILL_WIDTH-1:0]     capacity_now;
  logic [srq_pkg::COUNT_WIDTH-1:0]    enqueued_total;
  logic [srq_pkg::COUNT_WIDTH-1:0]    dequeued_total;

  modport source (output valid, output accepted, output item_out, output fill_level,
                  output capacity_now, output enqueued_total, output dequeued_total,
                  input ready);
  modport sink   (input valid, input accepted, input item_out, input fill_level,
                  input capacity_now, input enqueued_total, input dequeued_total,
                  output ready);
endinterface

// File: sv/srq_ctrl.sv
// Controller of the sequenced ring queue: sequences one item at a time.
// Depends on srq_pkg for the state type and the datapath command struct.
module srq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output srq_pkg::dp_cmd_t cmd_o
);

  srq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      srq_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = srq_pkg::ST_EXEC;
        end
      end
      srq_pkg::ST_EXEC: begin
        cmd_o.execute = 1'b1;
        state_d       = srq_pkg::ST_RESP;
      end
      srq_pkg::ST_RESP: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = srq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = srq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/srq_datapath.sv
// Datapath of the sequenced ring queue: item memory, counters, capacity register.
// Depends on srq_pkg; driven by commands from srq_ctrl.
module srq_datapath #(
  parameter int unsigned MAX_DEPTH  = srq_pkg::DEFAULT_MAX_DEPTH,
  parameter int unsigned ITEM_WIDTH = srq_pkg::DEFAULT_ITEM_WIDTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  srq_pkg::dp_cmd_t                    cmd_i,
  input  logic                                opcode_i,
  input  logic [ITEM_WIDTH-1:0]               payload_i,
  output logic                                accepted_o,
  output logic [ITEM_WIDTH-1:0]               item_out_o,
  output logic [srq_pkg::FILL_WIDTH-1:0]      fill_level_o,
  output logic [srq_pkg::FILL_WIDTH-1:0]      capacity_now_o,
  output logic [srq_pkg::COUNT_WIDTH-1:0]     enqueued_total_o,
  output logic [srq_pkg::COUNT_WIDTH-1:0]     dequeued_total_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [srq_pkg::APB_ADDR_WIDTH-1:0]  paddr,
  input  logic [srq_pkg::APB_DATA_WIDTH-1:0]  pwdata,
  output logic [srq_pkg::APB_DATA_WIDTH-1:0]  prdata
);

  localparam int unsigned AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int unsigned LW = $clog2(AW + 1);
  localparam int unsigned CW = srq_pkg::COUNT_WIDTH;

  // Effective log2 capacity: zero counts as one, large values saturate at the depth.
  function automatic logic [LW-1:0] eff_log2(input logic [srq_pkg::CFG_WIDTH-1:0] v);
    logic [LW-1:0] r;
    if (v == '0) begin
      r = LW'(1);
    end else if (32'(v) > AW) begin
      r = LW'(AW);
    end else begin
      r = LW'(v);
    end
    return r;
  endfunction

  logic [srq_pkg::CFG_WIDTH-1:0] cfg_q;
  logic [LW-1:0]                 cap_log_q;
  logic [CW-1:0]                 enq_cnt_q;
  logic [CW-1:0]                 deq_cnt_q;
  logic                          accepted_q;
  logic                          item_sel_q;
  logic                          opcode_q;
  logic [ITEM_WIDTH-1:0]         payload_q;
  logic [ITEM_WIDTH-1:0]         rdata_q;
  logic [ITEM_WIDTH-1:0]         mem [MAX_DEPTH];

  logic          cfg_wr;
  logic [AW:0]   cap;
  logic [AW-1:0] idx_mask;
  logic [AW:0]   occupancy;
  logic          is_deq;
  logic          op_ok;
  logic [AW-1:0] wr_idx;
  logic [AW-1:0] rd_idx;
  logic [31:0]   cap32;
  logic [CW-1:0] level;

  assign cfg_wr = psel && penable && pwrite && (paddr[2] == srq_pkg::REG_CAPACITY_LOG2);
  assign prdata = (paddr[2] == srq_pkg::REG_CAPACITY_LOG2)
                ? srq_pkg::APB_DATA_WIDTH'(cfg_q) : '0;

  // The positions equal the success counters modulo the ring size, and with
  // one operation at a time the occupancy alone decides full and empty.
  assign cap       = (AW + 1)'(1) << cap_log_q;
  assign idx_mask  = AW'(cap - (AW + 1)'(1));
  assign occupancy = enq_cnt_q[AW:0] - deq_cnt_q[AW:0];
  assign is_deq    = (opcode_q == srq_pkg::OP_DEQUEUE);
  assign op_ok     = is_deq ? (occupancy != '0) : (occupancy != cap);
  assign wr_idx    = enq_cnt_q[AW-1:0] & idx_mask;
  assign rd_idx    = deq_cnt_q[AW-1:0] & idx_mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q      <= srq_pkg::CAP_LOG2_RESET;
      cap_log_q  <= eff_log2(srq_pkg::CAP_LOG2_RESET);
      enq_cnt_q  <= '0;
      deq_cnt_q  <= '0;
      accepted_q <= 1'b0;
      item_sel_q <= 1'b0;
    end else if (cfg_wr) begin
      cfg_q     <= pwdata[srq_pkg::CFG_WIDTH-1:0];
      cap_log_q <= eff_log2(pwdata[srq_pkg::CFG_WIDTH-1:0]);
      enq_cnt_q <= '0;
      deq_cnt_q <= '0;
    end else if (cmd_i.execute) begin
      accepted_q <= op_ok;
      item_sel_q <= op_ok && is_deq;
      if (op_ok && !is_deq) begin
        enq_cnt_q <= enq_cnt_q + CW'(1);
      end
      if (op_ok && is_deq) begin
        deq_cnt_q <= deq_cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      opcode_q  <= opcode_i;
      payload_q <= payload_i;
    end
  end

  // Item memory: at most one write or one registered read per executed operation.
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute && op_ok && !is_deq) begin
      mem[wr_idx] <= payload_q;
    end
    if (cmd_i.execute && is_deq) begin
      rdata_q <= mem[rd_idx];
    end
  end

  assign cap32            = 32'(cap);
  assign level            = enq_cnt_q - deq_cnt_q;
  assign accepted_o       = accepted_q;
  assign item_out_o       = item_sel_q ? rdata_q : '0;
  assign fill_level_o     = level[srq_pkg::FILL_WIDTH-1:0];
  assign capacity_now_o   = cap32[srq_pkg::FILL_WIDTH-1:0];
  assign enqueued_total_o = enq_cnt_q;
  assign dequeued_total_o = deq_cnt_q;

endmodule

// File: sv/sequenced_ring_queue_top.sv
// Sequenced ring queue: a bounded ring of item words with a run-time capacity.
// Use: the request channel carries an opcode (enqueue or dequeue) and a payload
// word; every request yields exactly one response with an accepted flag, the
// dequeued word (zero otherwise), the fill level, the capacity in use and the
// wrapping totals of successful enqueues and dequeues.
// An enqueue on a full ring or a dequeue on an empty one is refused, not stalled.
// Timing: a request is taken in the idle cycle, executed in the next one (the
// single-port item memory is written or read there) and its response is shown
// from the cycle after. The block holds one item at a time, so a new request
// is taken only after the previous response transfer.
// If the receiver stalls, the response holds and requests wait.
// Reset clears the queue and sets the capacity register to 10 (1024 slots, or
// the memory depth rounded up to a power of two if smaller). The APB register
// at offset 0 holds log2 of the capacity; writing it empties the queue and
// clears both totals. pready is always high; write only while no request is in flight.
module sequenced_ring_queue_top #(
  parameter int unsigned MAX_DEPTH  = srq_pkg::DEFAULT_MAX_DEPTH,
  parameter int unsigned ITEM_WIDTH = srq_pkg::DEFAULT_ITEM_WIDTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  srq_req_if.sink                             req,
  srq_rsp_if.source                           rsp,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [srq_pkg::APB_ADDR_WIDTH-1:0]  paddr,
  input  logic [srq_pkg::APB_DATA_WIDTH-1:0]  pwdata,
  output logic [srq_pkg::APB_DATA_WIDTH-1:0]  prdata,
  output logic                                pready
);

  srq_pkg::dp_cmd_t cmd;

  assign pready = 1'b1;

  srq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .out_valid_o (rsp.valid),
    .out_ready_i (rsp.ready),
    .cmd_o       (cmd)
  );

  srq_datapath #(
    .MAX_DEPTH  (MAX_DEPTH),
    .ITEM_WIDTH (ITEM_WIDTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .opcode_i         (req.opcode),
    .payload_i        (req.payload),
    .accepted_o       (rsp.accepted),
    .item_out_o       (rsp.item_out),
    .fill_level_o     (rsp.fill_level),
    .capacity_now_o   (rsp.capacity_now),
    .enqueued_total_o (rsp.enqueued_total),
    .dequeued_total_o (rsp.dequeued_total),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata)
  );

endmodule
